@@ hdl/refcount_group_replacement_assert.svh @@
// assertion macros shared by the checker module
// no dependencies
`ifndef REFCOUNT_GROUP_REPLACEMENT_ASSERT_SVH
`define REFCOUNT_GROUP_REPLACEMENT_ASSERT_SVH
`define RGR_ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RGR_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("reset assertion failed");
`endif

@@ hdl/rgr_pkg.sv @@
// shared types and constants for the refcount group manager
// no dependencies
`default_nettype none
package rgr_pkg;
  localparam int NUM_GROUPS_DEF = 16;
  localparam int NUM_RESOURCES_DEF = 64;
  localparam int SLOTS_PER_RESOURCE_DEF = 8;
  localparam logic [2:0] MODE_INC  = 3'd0;
  localparam logic [2:0] MODE_DEC  = 3'd1;
  localparam logic [2:0] MODE_SET  = 3'd2;
  localparam logic [2:0] MODE_BIND = 3'd3;
  localparam logic [2:0] MODE_FIND = 3'd4;
  localparam logic [7:0] LEVEL_MAX = 8'hFF;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_OUT, ST_CLEAR} state_t;

  // declared from the highest bits down, so mode lands in the lowest bits
  typedef struct packed {
    logic [2:0] slot;
    logic [5:0] resource;
    logic [7:0] value;
    logic [1:0] level;
    logic [3:0] group;
    logic [2:0] mode;
  } item_t;

  // declared from the highest bits down, so group_out lands in the lowest bits
  typedef struct packed {
    logic [2:0] released_slot;
    logic [5:0] released_resource;
    logic       released;
    logic [7:0] counter_value;
    logic       found;
    logic [3:0] group_out;
  } result_t;
endpackage
`default_nettype wire

@@ hdl/rgr_slot_mem.sv @@
// slot table memory: one write port, one registered read port
// no dependencies
`default_nettype none
module rgr_slot_mem #(
  parameter int DEPTH = 512,
  parameter int AW = 9,
  parameter int DW = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/refcount_group_replacement.sv @@
// refcount group manager top level: group state, search, slot table control
// depends on rgr_pkg, rgr_slot_mem
//
//  channel | dir | payload
//  in_     | in  | tdata: mode, group, level, value, resource, slot
//  out_    | out | tdata: group_out, found, counter_value, released, rel res, rel slot
//  cfg_    | in  | protect_mask
//
// an item passes through accept (slot table read issued, read data registered),
// execute (group search and write back), then the result word in the output
// register; out_tvalid rises in ST_OUT, which follows ST_EXEC after accept
// after reset a clearing pass writes every slot table entry, one per cycle,
// and no item is accepted meanwhile
// out_tvalid holds until taken; no new item while a result waits
`default_nettype none
module refcount_group_replacement #(
  parameter int NUM_GROUPS = rgr_pkg::NUM_GROUPS_DEF,
  parameter int NUM_RESOURCES = rgr_pkg::NUM_RESOURCES_DEF,
  parameter int SLOTS_PER_RESOURCE = rgr_pkg::SLOTS_PER_RESOURCE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // mode[2:0], group[6:3], level[8:7], value[16:9], resource[22:17], slot[25:23]
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // group_out[3:0], found[4], counter_value[12:5], released[13],
  // released_resource[19:14], released_slot[22:20]
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import rgr_pkg::*;
  localparam int DEPTH = NUM_RESOURCES * SLOTS_PER_RESOURCE;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GW = $clog2(NUM_GROUPS) + 1; // group number plus unbound bit
  localparam int GI = $clog2(NUM_GROUPS);

  state_t state_r, state_nxt;
  item_t  item_r;
  result_t res_r, res_nxt;
  logic [15:0] mask_r;
  logic [AW:0] clr_r;
  logic [7:0]  lev_r [NUM_GROUPS][4];
  logic        bound_r [NUM_GROUPS];
  logic [5:0]  ores_r [NUM_GROUPS];
  logic [2:0]  oslot_r [NUM_GROUPS];

  logic          we;
  logic [AW-1:0] waddr, raddr, idx_r;
  logic [GW-1:0] wdata, rdata;

  // deferred unbind of the old owner when a bind took its group
  logic rel_pending_r;
  logic [AW-1:0] rel_addr_r;

  // address of a resource slot
  function automatic logic [AW-1:0] slot_addr(logic [5:0] r, logic [2:0] s);
    logic [31:0] a;
    a = 32'(r) * 32'(SLOTS_PER_RESOURCE) + 32'(s);
    return a[AW-1:0];
  endfunction

  item_t in_item;
  assign in_item = item_t'(in_tdata[25:0]);

  rgr_slot_mem #(.DEPTH(DEPTH), .AW(AW), .DW(GW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {1'b0, res_r};
  assign raddr      = slot_addr(in_item.resource, in_item.slot);

  // priority search over the four passes
  logic         hit;
  logic [GI-1:0] hit_g;
  always_comb begin
    logic [31:0] w;
    logic [31:0] m;
    hit = 1'b0;
    hit_g = '0;
    for (int p = 0; p < 4; p++) begin
      m = (p == 0) ? 32'hFFFFFFFF : (p == 1) ? 32'h00FFFFFF :
          (p == 2) ? 32'h0000FFFF : 32'h000000FF;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
        w = {lev_r[g][3], lev_r[g][2], lev_r[g][1], lev_r[g][0]};
        if (!hit && (w & m) == 32'd0 && !(g < 16 && mask_r[g % 16])) begin
          hit_g = GI'(g);
        end
      end
      for (int g = 0; g < NUM_GROUPS; g++) begin
        w = {lev_r[g][3], lev_r[g][2], lev_r[g][1], lev_r[g][0]};
        if ((w & m) == 32'd0 && !(g < 16 && mask_r[g % 16])) hit = 1'b1;
      end
      if (hit) break;
    end
  end

  // execute step, state sequencing and slot table write control
  logic       range_ok, res_ok, slot_hit;
  logic [7:0] cur, newv;
  logic       do_rel, do_bind, do_lev;
  logic [GI-1:0] rel_g;
  always_comb begin
    state_nxt = state_r;
    res_nxt = res_r;
    we = 1'b0;
    waddr = idx_r;
    wdata = {1'b1, {(GW-1){1'b0}}};
    do_rel = 1'b0;
    do_bind = 1'b0;
    do_lev = 1'b0;
    rel_g = item_r.group[GI-1:0];
    range_ok = (32'(item_r.group) < NUM_GROUPS);
    res_ok = (32'(item_r.resource) < NUM_RESOURCES) && (32'(item_r.slot) < SLOTS_PER_RESOURCE);
    slot_hit = !rdata[GW-1];
    cur = lev_r[item_r.group[GI-1:0]][item_r.level];
    newv = cur;
    case (item_r.mode)
      MODE_INC: newv = (cur == LEVEL_MAX) ? cur : cur + 8'd1;
      MODE_DEC: newv = (cur == 8'd0) ? cur : cur - 8'd1;
      MODE_SET: newv = item_r.value;
      default:  newv = cur;
    endcase
    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_r[AW-1:0];
        if (32'(clr_r) == DEPTH - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        res_nxt = '0;
        state_nxt = ST_OUT;
        case (item_r.mode)
          MODE_INC, MODE_SET: if (range_ok) begin
            do_lev = 1'b1;
            res_nxt.counter_value = newv;
          end
          MODE_DEC: if (range_ok) begin
            do_lev = 1'b1;
            res_nxt.counter_value = newv;
            do_rel = (cur == 8'd1) && bound_r[rel_g];
          end
          MODE_BIND: if (res_ok) begin
            if (slot_hit) begin
              res_nxt.group_out = 4'(rdata[GW-2:0]);
              res_nxt.found = 1'b1;
            end else if (hit) begin
              rel_g = hit_g;
              do_rel = bound_r[hit_g];
              do_bind = 1'b1;
              res_nxt.group_out = 4'(hit_g);
              res_nxt.found = 1'b1;
            end
          end
          MODE_FIND: if (hit) begin
            rel_g = hit_g;
            do_rel = bound_r[hit_g];
            res_nxt.group_out = 4'(hit_g);
            res_nxt.found = 1'b1;
          end
          default: ;
        endcase
        if (do_rel) begin
          res_nxt.released = 1'b1;
          res_nxt.released_resource = ores_r[rel_g];
          res_nxt.released_slot = oslot_r[rel_g];
          we = 1'b1;
          waddr = slot_addr(ores_r[rel_g], oslot_r[rel_g]);
        end
        // a bind takes the port; its unbind of the old owner waits for ST_OUT
        if (do_bind) begin
          we = 1'b1;
          waddr = idx_r;
          wdata = GW'(hit_g);
        end
      end
      ST_OUT: begin
        // old owner entry is bound to the stolen group, so it differs from the
        // newly bound slot; written before the next item can read
        if (rel_pending_r) begin
          we = 1'b1;
          waddr = rel_addr_r;
        end
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      mask_r <= '0;
      rel_pending_r <= 1'b0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        bound_r[g] <= 1'b0;
        ores_r[g] <= '0;
        oslot_r[g] <= '0;
        for (int l = 0; l < 4; l++) lev_r[g][l] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid) mask_r <= cfg_data;
      rel_pending_r <= do_rel && do_bind;
      if (do_lev) lev_r[item_r.group[GI-1:0]][item_r.level] <= newv;
      if (do_rel) begin
        bound_r[rel_g] <= 1'b0;
        ores_r[rel_g] <= '0;
        oslot_r[rel_g] <= '0;
      end
      if (do_bind) begin
        lev_r[hit_g][0] <= '0;
        bound_r[hit_g] <= 1'b1;
        ores_r[hit_g] <= item_r.resource;
        oslot_r[hit_g] <= item_r.slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
      idx_r <= raddr;
    end
    if (state_r == ST_EXEC) res_r <= res_nxt;
    rel_addr_r <= slot_addr(ores_r[rel_g], oslot_r[rel_g]);
  end

  // padding bits of the input word
  wire unused_ok = ^in_tdata[31:26];
endmodule
`default_nettype wire

@@ hdl/rgr_checker.sv @@
// port level checker for the refcount group manager, bound to the top level
// depends on the assertion macro header
`default_nettype none
`include "refcount_group_replacement_assert.svh"
module rgr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);
  `RGR_ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_tvalid |-> !in_tready)
  `RGR_ASSERT_IMPL(a_out_after_in, clk, rst_n, (in_tvalid && in_tready) |=> ##1 out_tvalid)
  `RGR_ASSERT_IMPL(a_hold, clk, rst_n, (out_tvalid && !out_tready) |=> $stable(out_tdata))
  `RGR_ASSERT_RST(a_rst_idle, clk, !rst_n |=> !out_tvalid)
endmodule
bind refcount_group_replacement rgr_checker u_chk (.*);
`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench for refcount_group_replacement: random and directed words
// depends on rgr_pkg and the block's rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import rgr_pkg::*;

  localparam int NGRP = 16;
  localparam int NRES = 64;
  localparam int NSLOT = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [2:0] mode;
    logic [3:0] group;
    logic [1:0] level;
    logic [7:0] value;
    logic [5:0] resource;
    logic [2:0] slot;
  } op_t;

  typedef struct {
    logic [3:0] group_out;
    logic       found;
    logic [7:0] counter_value;
    logic       released;
    logic [5:0] rel_res;
    logic [2:0] rel_slot;
  } answer_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [23:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  refcount_group_replacement uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow copy of the group manager state
  logic [7:0]  lvl_mem [NGRP*4];
  logic        bound_q [NGRP];
  logic [5:0]  own_res [NGRP];
  logic [2:0]  own_slot [NGRP];
  int          slot_map [NRES*NSLOT];   // -1 means unbound
  logic [15:0] prot_mask;

  op_t     pending_ops[$];
  answer_t expected_answers[$];
  int      errors = 0;

  bit send_quiet = 0;   // last part of the run: no gaps
  bit hold_send = 0;    // sender waits for the block to drain

  function automatic logic [31:0] levels_of(int g);
    return {lvl_mem[g*4+3], lvl_mem[g*4+2], lvl_mem[g*4+1], lvl_mem[g*4]};
  endfunction

  // frees the reverse binding of group g and notes it in the answer
  function automatic void unbind_group(int g, ref answer_t a);
    if (!bound_q[g]) return;
    slot_map[own_res[g]*NSLOT + own_slot[g]] = -1;
    a.released = 1;
    a.rel_res = own_res[g];
    a.rel_slot = own_slot[g];
    bound_q[g] = 0;
    own_res[g] = 0;
    own_slot[g] = 0;
  endfunction

  // four passes, narrowing the levels that must be zero
  function automatic int pick_free_group(ref answer_t a);
    logic [31:0] masks [4] = '{32'hFFFFFFFF, 32'h00FFFFFF, 32'h0000FFFF, 32'h000000FF};
    for (int p = 0; p < 4; p++)
      for (int g = 0; g < NGRP; g++)
        if ((levels_of(g) & masks[p]) == 0 && !prot_mask[g]) begin
          unbind_group(g, a);
          return g;
        end
    return -1;
  endfunction

  function automatic answer_t apply_op(op_t op);
    answer_t a = '{default: '0};
    int idx, f, k;
    case (op.mode)
      MODE_INC, MODE_DEC, MODE_SET: begin
        k = op.group*4 + op.level;
        if (op.mode == MODE_INC) begin
          if (lvl_mem[k] != LEVEL_MAX) lvl_mem[k]++;
        end else if (op.mode == MODE_DEC) begin
          if (lvl_mem[k] != 0) begin
            lvl_mem[k]--;
            if (lvl_mem[k] == 0) unbind_group(op.group, a);
          end
        end else begin
          lvl_mem[k] = op.value;
        end
        a.counter_value = lvl_mem[k];
      end
      MODE_BIND: begin
        idx = op.resource*NSLOT + op.slot;
        if (slot_map[idx] >= 0) begin
          a.group_out = 4'(slot_map[idx]);
          a.found = 1;
        end else begin
          f = pick_free_group(a);
          if (f >= 0) begin
            lvl_mem[f*4] = 0;
            slot_map[idx] = f;
            bound_q[f] = 1;
            own_res[f] = op.resource;
            own_slot[f] = op.slot;
            a.group_out = 4'(f);
            a.found = 1;
          end
        end
      end
      MODE_FIND: begin
        f = pick_free_group(a);
        if (f >= 0) begin
          a.group_out = 4'(f);
          a.found = 1;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic op_t make_op(logic [2:0] m, logic [3:0] g, logic [1:0] l,
                                  logic [7:0] v, logic [5:0] r, logic [2:0] s);
    op_t o;
    o.mode = m; o.group = g; o.level = l; o.value = v; o.resource = r; o.slot = s;
    return o;
  endfunction

  function automatic op_t random_op();
    op_t o;
    int pick = $urandom_range(0, 99);
    o = make_op(3'($urandom_range(0, 7)), 4'($urandom), 2'($urandom), 8'($urandom),
                6'($urandom), 3'($urandom));
    // mostly bind, find and refcount traffic over a small set of resources
    if (pick < 30) begin
      o.mode = MODE_BIND;
      if (pick < 22) o.resource = 6'($urandom_range(0, 5));
    end else if (pick < 40) o.mode = MODE_FIND;
    else if (pick < 62) o.mode = MODE_INC;
    else if (pick < 84) o.mode = MODE_DEC;
    else if (pick < 94) begin
      o.mode = MODE_SET;
      if ($urandom_range(0, 1)) o.value = 8'($urandom_range(0, 2));
    end
    return o;
  endfunction

  // driver: presents pending words with random gaps
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_answers.push_back(apply_op(pending_ops.pop_front()));
        if (!send_quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 9);
      end
      if (in_tvalid && !in_tready) begin
        // hold current word
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 0;
      end else if (pending_ops.size() > 0 && !hold_send) begin
        in_tvalid <= 1;
        in_tdata <= {6'd0, pending_ops[0].slot, pending_ops[0].resource, pending_ops[0].value,
                     pending_ops[0].level, pending_ops[0].group, pending_ops[0].mode};
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // monitor: checks each result word and stalls the output at random
  int stall_left = 0;
  always @(posedge clk) begin
    answer_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result word, actual %h", $time, out_tdata);
          errors++;
        end else begin
          e = expected_answers.pop_front();
          if (out_tdata[3:0] !== e.group_out || out_tdata[4] !== e.found ||
              out_tdata[12:5] !== e.counter_value || out_tdata[13] !== e.released ||
              out_tdata[19:14] !== e.rel_res || out_tdata[22:20] !== e.rel_slot) begin
            $display("%0t: mismatch expected grp=%h fnd=%b cnt=%h rel=%b res=%h slot=%h",
                     $time, e.group_out, e.found, e.counter_value, e.released,
                     e.rel_res, e.rel_slot);
            $display("%0t:          actual   grp=%h fnd=%b cnt=%h rel=%b res=%h slot=%h",
                     $time, out_tdata[3:0], out_tdata[4], out_tdata[12:5], out_tdata[13],
                     out_tdata[19:14], out_tdata[22:20]);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 0;
      end else if (!send_quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  // cycle limit
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_tvalid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask(logic [15:0] m);
    cfg_valid <= 1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    prot_mask = m;
    cfg_valid <= 0;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_ops.push_back(random_op());
    wait_drained();
  endtask

  initial begin
    prot_mask = 0;
    for (int i = 0; i < NGRP*4; i++) lvl_mem[i] = 0;
    for (int g = 0; g < NGRP; g++) begin
      bound_q[g] = 0; own_res[g] = 0; own_slot[g] = 0;
    end
    for (int i = 0; i < NRES*NSLOT; i++) slot_map[i] = -1;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, every mode, saturation, release on zero, reuse order
    write_mask(16'h0000);
    pending_ops.push_back(make_op(MODE_BIND, 0, 0, 0, 6'd63, 3'd7));
    pending_ops.push_back(make_op(MODE_BIND, 0, 0, 0, 6'd63, 3'd7));   // already bound
    pending_ops.push_back(make_op(MODE_BIND, 0, 0, 0, 6'd0, 3'd0));
    pending_ops.push_back(make_op(MODE_DEC, 4'd0, 2'd3, 0, 0, 0));     // decrement at zero
    pending_ops.push_back(make_op(MODE_SET, 4'd15, 2'd3, 8'hFF, 0, 0));
    pending_ops.push_back(make_op(MODE_INC, 4'd15, 2'd3, 0, 0, 0));    // saturation
    pending_ops.push_back(make_op(MODE_INC, 4'd0, 2'd0, 0, 0, 0));
    pending_ops.push_back(make_op(MODE_DEC, 4'd0, 2'd0, 0, 0, 0));     // release on zero
    pending_ops.push_back(make_op(MODE_SET, 4'd1, 2'd2, 8'h01, 0, 0));
    pending_ops.push_back(make_op(MODE_SET, 4'd2, 2'd1, 8'h80, 0, 0));
    pending_ops.push_back(make_op(MODE_FIND, 0, 0, 0, 0, 0));          // finds the group released above, none bound
    pending_ops.push_back(make_op(3'd5, 4'hF, 2'd3, 8'hFF, 6'h3F, 3'd7));
    pending_ops.push_back(make_op(3'd6, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(3'd7, 0, 0, 0, 0, 0));
    wait_drained();
    write_mask(16'hFFFF);                                               // nothing reusable
    pending_ops.push_back(make_op(MODE_FIND, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(MODE_BIND, 0, 0, 0, 6'd9, 3'd4));
    pending_ops.push_back(make_op(MODE_BIND, 0, 0, 0, 6'd63, 3'd7));
    wait_drained();

    // random phases under several masks
    write_mask(16'h0000);
    run_random(300);
    write_mask(16'h8001);
    for (int i = 0; i < 150; i++) pending_ops.push_back(random_op());
    repeat (200) @(posedge clk);
    hold_send <= 1;                     // sender waits until every result is back
    wait_drained();
    write_mask(16'h7FFE);
    run_random(250);
    write_mask(16'($urandom));
    run_random(300);
    write_mask(16'hFFFF);
    run_random(100);
    write_mask(16'h0000);
    send_quiet = 1;
    run_random(320);

    repeat (20) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // sender pause: release the hold once the block has drained
  always @(posedge clk) begin
    if (hold_send && expected_answers.size() == 0 && !in_tvalid) hold_send <= 0;
  end
endmodule
`default_nettype wire
